/* design/dstbp_pkg.sv */
`timescale 1ns / 1ps

package dstbp_pkg;

	// Fixed field widths
	localparam int ID_W   = 8;
	localparam int LOW_W  = 9;
	localparam int FCNT_W = 9;
	localparam int TOT_W  = 32;
	localparam int FUNC_W = 2;

	// Function codes on the input stream
	localparam logic [FUNC_W-1:0] FUNC_GET      = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FREE     = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CQ_EMPTY = 2'd2;

	// Configuration register indexes
	localparam int CFG_ADDR_W = 1;
	localparam logic [CFG_ADDR_W-1:0] REG_LOW_WATER    = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_PORT_STARTED = 1'b1;

	// Register reset values
	localparam logic [LOW_W-1:0] LOW_WATER_RST    = 9'd16;
	localparam logic             PORT_STARTED_RST = 1'b1;

	// Per-item result flags from the control unit
	typedef struct packed {
		logic granted;
		logic no_buffer;
		logic tx_update;
		logic overflow;
		logic pop_one;
	} step_flags_t;

endpackage

/* design/dstbp_stack_mem.sv */
`timescale 1ns / 1ps

module dstbp_stack_mem #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8,
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/dstbp_ctrl.sv */
`timescale 1ns / 1ps

module dstbp_ctrl #(
	parameter int NUM_BUFFERS = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dstbp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [dstbp_pkg::LOW_W-1:0]       cfg_wdata,
	input  logic                              accept,
	input  logic [dstbp_pkg::FUNC_W-1:0]      func,
	input  logic                              from_failure,
	output dstbp_pkg::step_flags_t            flags,
	output logic                              pop_en,
	output logic                              pop_sel,
	output logic [$clog2(NUM_BUFFERS)-1:0]    pop_addr,
	output logic                              push_en,
	output logic                              push_sel,
	output logic [$clog2(NUM_BUFFERS)-1:0]    push_addr,
	output logic [dstbp_pkg::FCNT_W-1:0]      free_count,
	output logic [dstbp_pkg::TOT_W-1:0]       resched_total,
	output logic [dstbp_pkg::TOT_W-1:0]       nobuf_total
);

	import dstbp_pkg::*;

	localparam int AW = $clog2(NUM_BUFFERS);
	localparam int CW = $clog2(NUM_BUFFERS + 1);
	localparam int XW = (CW > LOW_W) ? CW : LOW_W;
	localparam logic [CW-1:0] NUM_C = CW'(NUM_BUFFERS);

	logic [LOW_W-1:0] low_water_q;
	logic             port_started_q;
	logic [CW-1:0]    cnt0_q, cnt1_q, free_total_q;
	logic             take_one_q, pend_q;
	logic [TOT_W-1:0] resched_q, nobuf_q;

	logic [CW-1:0]    cnt0_nxt, cnt1_nxt, free_total_nxt;
	logic             take_one_nxt, pend_nxt;
	logic [TOT_W-1:0] resched_nxt, nobuf_nxt;
	logic [CW-1:0]    tc, rc, rc_inc, tc_dec, rc_dec;
	logic [XW-1:0]    low_x, ft_x;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_water_q    <= LOW_WATER_RST;
			port_started_q <= PORT_STARTED_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_LOW_WATER:    low_water_q    <= cfg_wdata;
				REG_PORT_STARTED: port_started_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign tc     = take_one_q ? cnt1_q : cnt0_q;
	assign rc     = take_one_q ? cnt0_q : cnt1_q;
	assign rc_inc = rc + 1'b1;
	assign tc_dec = tc - 1'b1;
	assign rc_dec = rc - 1'b1;
	assign low_x  = XW'(low_water_q);
	assign ft_x   = XW'(free_total_q);

	// Step decision and next state
	always_comb begin
		flags          = '0;
		pop_sel        = 1'b0;
		pop_addr       = '0;
		push_sel       = ~take_one_q;
		push_addr      = rc[AW-1:0];
		cnt0_nxt       = cnt0_q;
		cnt1_nxt       = cnt1_q;
		free_total_nxt = free_total_q;
		take_one_nxt   = take_one_q;
		pend_nxt       = pend_q;
		resched_nxt    = resched_q;
		nobuf_nxt      = nobuf_q;
		push_en        = 1'b0;
		case (func)
			FUNC_GET: begin
				if (tc != '0) begin
					flags.granted = 1'b1;
					pop_sel       = take_one_q;
					pop_addr      = tc_dec[AW-1:0];
					if (take_one_q) cnt1_nxt = tc_dec;
					else            cnt0_nxt = tc_dec;
				end else if (rc != '0) begin
					flags.granted = 1'b1;
					pop_sel       = ~take_one_q;
					pop_addr      = rc_dec[AW-1:0];
					if (take_one_q) cnt0_nxt = rc_dec;
					else            cnt1_nxt = rc_dec;
				end else begin
					flags.no_buffer = 1'b1;
					nobuf_nxt       = nobuf_q + 1'b1;
					pend_nxt        = 1'b1;
				end
				if (flags.granted && free_total_q != '0) begin
					free_total_nxt = free_total_q - 1'b1;
				end
			end
			FUNC_FREE: begin
				if (port_started_q || from_failure) begin
					if (free_total_q >= NUM_C || rc >= NUM_C) begin
						flags.overflow = 1'b1;
					end else begin
						push_en        = 1'b1;
						free_total_nxt = free_total_q + 1'b1;
						if (take_one_q) cnt0_nxt = rc_inc;
						else            cnt1_nxt = rc_inc;
						// swap roles when the take side runs low
						if (XW'(tc) < low_x && tc < rc_inc) begin
							take_one_nxt = ~take_one_q;
						end
					end
					if (from_failure) pend_nxt = 1'b1;
				end
			end
			FUNC_CQ_EMPTY: begin
				if (pend_q && ft_x > low_x) begin
					pend_nxt        = 1'b0;
					flags.tx_update = 1'b1;
					resched_nxt     = resched_q + 1'b1;
				end
			end
			default: ;
		endcase
		flags.pop_one = pop_sel;
	end

	assign pop_en = accept && flags.granted;

	// Pool state, updated per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt0_q       <= '0;
			cnt1_q       <= '0;
			free_total_q <= '0;
			take_one_q   <= 1'b0;
			pend_q       <= 1'b0;
			resched_q    <= '0;
			nobuf_q      <= '0;
		end else if (accept) begin
			cnt0_q       <= cnt0_nxt;
			cnt1_q       <= cnt1_nxt;
			free_total_q <= free_total_nxt;
			take_one_q   <= take_one_nxt;
			pend_q       <= pend_nxt;
			resched_q    <= resched_nxt;
			nobuf_q      <= nobuf_nxt;
		end
	end

	assign free_count    = ft_x[FCNT_W-1:0];
	assign resched_total = resched_q;
	assign nobuf_total   = nobuf_q;

`ifndef SYNTHESIS
	a_total_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(CW+1)'(free_total_q) == (CW+1)'(cnt0_q) + (CW+1)'(cnt1_q))
		else $error("free total differs from stack fill levels");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt0_q <= NUM_C && cnt1_q <= NUM_C)
		else $error("stack fill level above pool size");

	a_nobuf_pends: assert property (@(posedge clk) disable iff (!arst_n)
		accept && flags.no_buffer |=> pend_q)
		else $error("failed get did not mark reschedule");

	a_update_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && flags.tx_update |=> !pend_q && resched_q == $past(resched_q) + 1'b1)
		else $error("transmit update did not clear pending reschedule");
`endif

endmodule

/* design/dual_stack_tx_buffer_pool_core.sv */
`timescale 1ns / 1ps

// Transmit buffer pool built from two LIFO stacks of 8-bit buffer ids held in
// synchronous RAMs, with fill levels, role select and counters in flops. Each
// item on the input stream (get, free or completion-empty) gives exactly one
// result item. After its item is taken, a result passes the registered stack
// RAM read (stage 1) and then the output register. Items are taken one per
// cycle as long as results are drained; a free writes the RAM at the accept
// edge and a following get reads it at its later accept edge, so no hazard
// exists. Stacks start empty and need no clearing pass; they are seeded by free
// items. Write configuration only while idle; the block does not enforce it.
module dual_stack_tx_buffer_pool_core #(
	parameter int NUM_BUFFERS = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration writes
	input  logic                              cfg_we,
	input  logic [dstbp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [dstbp_pkg::LOW_W-1:0]       cfg_wdata,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,  // buf_id[7:0]
	input  logic [2:0]                        s_tuser,  // func[1:0], from_failure[2]
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// out_id[7:0], free_count[16:8], resched_total[48:17], nobuf_total[80:49]
	output logic [87:0]                       m_tdata,
	// granted[0], no_buffer[1], tx_update[2], overflow[3]
	output logic [3:0]                        m_tuser
);

	import dstbp_pkg::*;

	localparam int AW = $clog2(NUM_BUFFERS);

	step_flags_t         flags, flags_s1;
	logic                valid_s1;
	logic                accept, out_free, s1_adv;
	logic                pop_en, pop_sel, push_en, push_sel;
	logic [AW-1:0]       pop_addr, push_addr;
	logic [ID_W-1:0]     rdata0, rdata1, id_pop;
	logic [FCNT_W-1:0]   free_count;
	logic [TOT_W-1:0]    resched_total, nobuf_total;

	logic                m_valid_q;
	logic [ID_W-1:0]     out_id_q;
	logic [FCNT_W-1:0]   free_count_q;
	logic [TOT_W-1:0]    resched_q, nobuf_q;
	logic [3:0]          res_flags_q;

	// Handshake: result register parts the stages
	assign out_free = !m_valid_q || m_tready;
	assign s1_adv   = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	dstbp_ctrl #(
		.NUM_BUFFERS(NUM_BUFFERS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.accept        (accept),
		.func          (s_tuser[1:0]),
		.from_failure  (s_tuser[2]),
		.flags         (flags),
		.pop_en        (pop_en),
		.pop_sel       (pop_sel),
		.pop_addr      (pop_addr),
		.push_en       (push_en),
		.push_sel      (push_sel),
		.push_addr     (push_addr),
		.free_count    (free_count),
		.resched_total (resched_total),
		.nobuf_total   (nobuf_total)
	);

	dstbp_stack_mem #(
		.DEPTH (NUM_BUFFERS),
		.ADDR_W(AW),
		.DATA_W(ID_W)
	) u_stack0 (
		.clk  (clk),
		.we   (accept && push_en && !push_sel),
		.waddr(push_addr),
		.wdata(s_tdata[ID_W-1:0]),
		.re   (pop_en && !pop_sel),
		.raddr(pop_addr),
		.rdata(rdata0)
	);

	dstbp_stack_mem #(
		.DEPTH (NUM_BUFFERS),
		.ADDR_W(AW),
		.DATA_W(ID_W)
	) u_stack1 (
		.clk  (clk),
		.we   (accept && push_en && push_sel),
		.waddr(push_addr),
		.wdata(s_tdata[ID_W-1:0]),
		.re   (pop_en && pop_sel),
		.raddr(pop_addr),
		.rdata(rdata1)
	);

	// Stage 1: waiting on the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1 <= flags;
		end
	end

	assign id_pop = flags_s1.pop_one ? rdata1 : rdata0;

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_id_q     <= flags_s1.granted ? id_pop : '0;
			free_count_q <= free_count;
			resched_q    <= resched_total;
			nobuf_q      <= nobuf_total;
			res_flags_q  <= {flags_s1.overflow, flags_s1.tx_update,
			                 flags_s1.no_buffer, flags_s1.granted};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, nobuf_q, resched_q, free_count_q, out_id_q};
	assign m_tuser  = res_flags_q;

`ifndef SYNTHESIS
	a_read_follows_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop_en |=> valid_s1 && flags_s1.granted)
		else $error("stack read without a granted item in stage 1");

	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !(push_en && flags.granted))
		else $error("one item both pushed and popped");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $countones({flags_s1.granted, flags_s1.no_buffer,
		            flags_s1.tx_update, flags_s1.overflow}) <= 1)
		else $error("more than one result flag set");
`endif

endmodule

/* tb/dual_stack_tx_buffer_pool_core_tb.sv */
`timescale 1ns / 1ps

module dual_stack_tx_buffer_pool_core_tb;
	import dstbp_pkg::*;

	localparam int POOL_SIZE = 256;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	// func code the block must treat as a no-op
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ID_W-1:0]   buf_id;
		logic              from_failure;
	} pool_cmd_t;

	typedef struct packed {
		logic              granted;
		logic [ID_W-1:0]   out_id;
		logic              no_buffer;
		logic              tx_update;
		logic              overflow;
		logic [FCNT_W-1:0] free_count;
		logic [TOT_W-1:0]  resched_total;
		logic [TOT_W-1:0]  nobuf_total;
	} pool_result_t;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [LOW_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic [3:0] m_tuser;

	dual_stack_tx_buffer_pool_core #(.NUM_BUFFERS(POOL_SIZE)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),   // buf_id[7:0]
		.s_tuser(s_tuser),   // func[1:0], from_failure[2]
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		// out_id[7:0], free_count[16:8], resched_total[48:17], nobuf_total[80:49]
		.m_tdata(m_tdata),
		// granted[0], no_buffer[1], tx_update[2], overflow[3]
		.m_tuser(m_tuser)
	);

	// Shadow of the pool state and registers
	logic [ID_W-1:0] shadow_stack [0:1][0:POOL_SIZE-1];
	int unsigned shadow_count [0:1];
	bit shadow_take_one;
	bit shadow_resched;
	int unsigned shadow_free;
	logic [TOT_W-1:0] shadow_resched_cnt;
	logic [TOT_W-1:0] shadow_nobuf_cnt;
	logic [LOW_W-1:0] shadow_low_water;
	bit shadow_started;

	pool_cmd_t cmd_q[$];
	pool_result_t pool_result_q[$];
	pool_cmd_t cur_cmd;
	pool_result_t got_want;
	int errors = 0;
	int burst_left = 0;
	int gap_left = 0;
	int idle_cycles = 0;
	int rx_mode = 0;
	int rx_mode_left = 0;
	int rx_tick = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one item to the shadow pool and return what the block should report
	function automatic pool_result_t pool_apply(pool_cmd_t c);
		pool_result_t r;
		bit ret;
		r = '0;
		case (c.func)
			FUNC_GET: begin
				if (shadow_count[shadow_take_one] != 0) begin
					shadow_count[shadow_take_one]--;
					r.out_id = shadow_stack[shadow_take_one][shadow_count[shadow_take_one]];
					r.granted = 1'b1;
				end else if (shadow_count[!shadow_take_one] != 0) begin
					shadow_count[!shadow_take_one]--;
					r.out_id = shadow_stack[!shadow_take_one][shadow_count[!shadow_take_one]];
					r.granted = 1'b1;
				end
				if (r.granted) begin
					if (shadow_free > 0)
						shadow_free--;
				end else begin
					r.no_buffer = 1'b1;
					shadow_nobuf_cnt++;
					shadow_resched = 1'b1;
				end
			end
			FUNC_FREE: begin
				if (shadow_started || c.from_failure) begin
					if (shadow_free >= POOL_SIZE) begin
						r.overflow = 1'b1;
					end else begin
						ret = !shadow_take_one;
						shadow_stack[ret][shadow_count[ret]] = c.buf_id;
						shadow_count[ret]++;
						shadow_free++;
						// swap roles when the take side runs low
						if (shadow_count[shadow_take_one] < shadow_low_water &&
						    shadow_count[shadow_take_one] < shadow_count[ret])
							shadow_take_one = ret;
					end
					if (c.from_failure)
						shadow_resched = 1'b1;
				end
			end
			FUNC_CQ_EMPTY: begin
				if (shadow_resched && shadow_free > shadow_low_water) begin
					shadow_resched = 1'b0;
					r.tx_update = 1'b1;
					shadow_resched_cnt++;
				end
			end
			default: ;
		endcase
		r.free_count = shadow_free[FCNT_W-1:0];
		r.resched_total = shadow_resched_cnt;
		r.nobuf_total = shadow_nobuf_cnt;
		return r;
	endfunction

	function automatic void check_field(string name, logic [TOT_W-1:0] want, logic [TOT_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	function automatic pool_cmd_t make_cmd(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id,
			logic fail);
		pool_cmd_t c;
		c.func = fn;
		c.buf_id = id;
		c.from_failure = fail;
		return c;
	endfunction

	// Random item biased toward filling, draining or a balanced mix
	function automatic pool_cmd_t rand_cmd(mix_t mix);
		pool_cmd_t c;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		c.buf_id = ID_W'($urandom_range(0, 255));
		c.from_failure = ($urandom_range(0, 4) == 0);
		case (mix)
			MIX_FILL: c.func = (roll < 85) ? FUNC_FREE : (roll < 95) ? FUNC_GET : FUNC_CQ_EMPTY;
			MIX_DRAIN: c.func = (roll < 85) ? FUNC_GET : (roll < 95) ? FUNC_FREE : FUNC_CQ_EMPTY;
			default: c.func = (roll < 40) ? FUNC_GET : (roll < 80) ? FUNC_FREE : FUNC_CQ_EMPTY;
		endcase
		if ($urandom_range(0, 59) == 0)
			c.func = FUNC_UNUSED;
		return c;
	endfunction

	// Block is idle once nothing is queued, presented or outstanding
	task automatic wait_idle();
		do
			@(negedge clk);
		while (cmd_q.size() != 0 || s_tvalid || pool_result_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [LOW_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (addr == REG_LOW_WATER)
			shadow_low_water = val;
		else
			shadow_started = val[0];
	endtask

	task automatic run_phase(mix_t mix, logic [LOW_W-1:0] low, logic started, int n);
		wait_idle();
		write_reg(REG_LOW_WATER, low);
		write_reg(REG_PORT_STARTED, {{(LOW_W-1){1'b0}}, started});
		repeat (n) cmd_q.push_back(rand_cmd(mix));
	endtask

	// Stimulus sequence
	initial begin
		shadow_count[0] = 0;
		shadow_count[1] = 0;
		shadow_take_one = 1'b0;
		shadow_resched = 1'b0;
		shadow_free = 0;
		shadow_resched_cnt = '0;
		shadow_nobuf_cnt = '0;
		shadow_low_water = LOW_WATER_RST;
		shadow_started = PORT_STARTED_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty get, no-op code, LIFO order, duplicates
		cmd_q.push_back(make_cmd(FUNC_GET, 8'h00, 1'b0));
		cmd_q.push_back(make_cmd(FUNC_CQ_EMPTY, 8'h00, 1'b0));
		cmd_q.push_back(make_cmd(FUNC_UNUSED, 8'hFF, 1'b1));
		cmd_q.push_back(make_cmd(FUNC_FREE, 8'hFF, 1'b0));
		cmd_q.push_back(make_cmd(FUNC_FREE, 8'h00, 1'b0));
		cmd_q.push_back(make_cmd(FUNC_GET, 8'h00, 1'b0));
		cmd_q.push_back(make_cmd(FUNC_FREE, 8'hA5, 1'b1));
		cmd_q.push_back(make_cmd(FUNC_FREE, 8'hA5, 1'b0));
		repeat (4) cmd_q.push_back(make_cmd(FUNC_GET, 8'h00, 1'b0));

		// directed: low mark at zero lets the pending reschedule fire
		wait_idle();
		write_reg(REG_LOW_WATER, 9'd0);
		cmd_q.push_back(make_cmd(FUNC_CQ_EMPTY, 8'h00, 1'b0));
		cmd_q.push_back(make_cmd(FUNC_FREE, 8'h07, 1'b0));
		cmd_q.push_back(make_cmd(FUNC_CQ_EMPTY, 8'h00, 1'b0));
		cmd_q.push_back(make_cmd(FUNC_CQ_EMPTY, 8'h00, 1'b0));

		// directed: port stopped, plain free ignored, failure free taken
		wait_idle();
		write_reg(REG_PORT_STARTED, 9'd0);
		cmd_q.push_back(make_cmd(FUNC_FREE, 8'h3C, 1'b0));
		cmd_q.push_back(make_cmd(FUNC_FREE, 8'hC3, 1'b1));
		cmd_q.push_back(make_cmd(FUNC_UNUSED, 8'h00, 1'b0));
		cmd_q.push_back(make_cmd(FUNC_GET, 8'h00, 1'b0));
		cmd_q.push_back(make_cmd(FUNC_GET, 8'h00, 1'b0));

		// random: fill to overflow, drain to empty, with extreme low marks
		run_phase(MIX_FILL, 9'd0, 1'b1, 130);
		run_phase(MIX_FILL, 9'd256, 1'b1, 130);
		run_phase(MIX_FILL, LOW_W'($urandom_range(1, 255)), 1'b1, 130);
		run_phase(MIX_EVEN, LOW_W'($urandom_range(0, 256)), 1'b0, 100);
		run_phase(MIX_DRAIN, 9'd256, 1'b1, 130);
		run_phase(MIX_DRAIN, 9'd0, 1'b1, 130);
		run_phase(MIX_DRAIN, LOW_W'($urandom_range(1, 255)), 1'b1, 130);
		run_phase(MIX_EVEN, 9'd16, 1'($urandom_range(0, 1)), 110);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pool_result_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Input driver: bursts of items with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				pool_result_q.push_back(pool_apply(cur_cmd));
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					s_tvalid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (cmd_q.size() != 0) begin
					cur_cmd = cmd_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= cur_cmd.buf_id;
					s_tuser <= {cur_cmd.from_failure, cur_cmd.func};
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stall pattern
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pool_result_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0h/%0h",
						$time, m_tuser, m_tdata);
					errors++;
				end else begin
					got_want = pool_result_q.pop_front();
					check_field("granted", TOT_W'(got_want.granted), TOT_W'(m_tuser[0]));
					check_field("no_buffer", TOT_W'(got_want.no_buffer), TOT_W'(m_tuser[1]));
					check_field("tx_update", TOT_W'(got_want.tx_update), TOT_W'(m_tuser[2]));
					check_field("overflow", TOT_W'(got_want.overflow), TOT_W'(m_tuser[3]));
					check_field("out_id", TOT_W'(got_want.out_id), TOT_W'(m_tdata[7:0]));
					check_field("free_count", TOT_W'(got_want.free_count),
						TOT_W'(m_tdata[16:8]));
					check_field("resched_total", got_want.resched_total, m_tdata[48:17]);
					check_field("nobuf_total", got_want.nobuf_total, m_tdata[80:49]);
				end
			end
			rx_tick <= rx_tick + 1;
			if (rx_mode_left == 0) begin
				rx_mode <= $urandom_range(0, 3);
				rx_mode_left <= $urandom_range(30, 200);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (rx_tick % 5 == 0);
				default: m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Watchdog on cycles without any accepted item or delivered result
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule
